// ===== hw/rtl/bpfa_pkg.sv =====
// Package for the bitmap page-frame allocator.
// Holds the controller state type, status and register codes, and entry helpers.
// No dependencies.
package bpfa_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_BAD, ST_A_SCAN, ST_A_EMIT, ST_R_RD, ST_R_WR,
    ST_OOM_RD, ST_OOM_EMIT, ST_F_RD, ST_F_CHK, ST_F_WR
  } state_t;

  localparam logic [2:0] STAT_MAPPED  = 3'd0;
  localparam logic [2:0] STAT_FREED   = 3'd1;
  localparam logic [2:0] STAT_SKIPPED = 3'd2;
  localparam logic [2:0] STAT_OOM     = 3'd3;
  localparam logic [2:0] STAT_BAD     = 3'd4;

  localparam logic [1:0] CFG_TOTAL_FRAMES = 2'd0;
  localparam logic [1:0] CFG_USER_ACCESS  = 2'd1;
  localparam logic [1:0] CFG_READ_ONLY    = 2'd2;

  localparam logic        REQ_FREE     = 1'b1;
  localparam logic [31:0] FULL_WORD    = 32'hFFFF_FFFF;
  localparam logic [19:0] FRAME_BASE_PG = 20'h00800;

  // Lowest clear bit of a bitmap word; 31 when bits 30..0 are all set.
  function automatic logic [4:0] lowest_clear(input logic [31:0] v);
    logic [4:0] b;
    b = 5'd31;
    for (int i = 30; i >= 0; i--) begin
      if (!v[i]) begin
        b = 5'(i);
      end
    end
    return b;
  endfunction

  // Page-table entry: frame address, user, writable and present bits.
  function automatic logic [31:0] make_entry(input logic [12:0] frame,
                                             input logic user, input logic ro);
    logic [19:0] pg;
    pg = 20'(frame) + FRAME_BASE_PG;
    return {pg, 9'd0, user, ~ro, 1'b1};
  endfunction

endpackage

// ===== hw/rtl/bpfa_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the frame bitmap and the page table. No dependencies.
module bpfa_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page-frame allocator: controller and both memories.
// Depends on bpfa_pkg and bpfa_ram.
//
// Usage. A request (req_type, first_page, page_count) is taken at a rising edge
// where start is high and busy is low. The block then works on that request
// alone and raises busy until its last result has gone out. Results appear one
// per cycle-long pulse of result_valid; the receiver cannot stall them, so each
// result is a transfer in the cycle it is shown; the final one carries last = 1.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and writes belong in idle periods.
// After reset the block sweeps the page table (one entry a cycle) and the bitmap
// alongside it, holding busy high; configuration writes are still taken during
// that sweep.
// Flow. Each allocated page scans the bitmap one word a cycle from word zero.
// Allocation results then follow at one a cycle. Freeing takes a table read,
// a check and bitmap read, and a write back per page; a skipped page has no
// write back. A rollback reads and writes back each page to undo, then reads
// the table entry of the failed page and reports it. The bitmap scan through
// the single read port sets the rate.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int BITMAP_WORDS  = 128,
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_RUN       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [9:0]  first_page,
  input  logic [4:0]  page_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        result_valid,
  output logic [9:0]  page_index,
  output logic [11:0] frame_offset,
  output logic [31:0] entry_word,
  output logic [2:0]  status,
  output logic        last
);

  localparam int BAW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int FW  = BAW + 5;
  localparam int CW0 = $clog2(MAX_RUN + 1);
  localparam int NW  = (CW0 > 5) ? CW0 : 5;
  localparam int RW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  // Configuration registers.
  logic [12:0] total_frames;
  logic        user_access;
  logic        read_only;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= 13'd4096;
      user_access  <= 1'b0;
      read_only    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOTAL_FRAMES: total_frames <= cfg_data;
        CFG_USER_ACCESS:  user_access  <= cfg_data[0];
        CFG_READ_ONLY:    read_only    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memory ports.
  logic            bm_we;
  logic [BAW-1:0]  bm_waddr, bm_raddr;
  logic [31:0]     bm_wdata, bm_rdata;
  logic            pt_we;
  logic [TAW-1:0]  pt_waddr, pt_raddr;
  logic [31:0]     pt_wdata, pt_rdata;

  bpfa_ram #(.DEPTH(BITMAP_WORDS), .WIDTH(32)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  bpfa_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(32)) u_table (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  // Controller registers.
  state_t          state, state_next;
  logic [TAW-1:0]  clr;
  logic [TAW-1:0]  first_r;
  logic [NW-1:0]   count_r;
  logic [NW-1:0]   n;
  logic [NW-1:0]   j;
  logic [8:0]      scan_addr;
  logic            chk_valid;
  logic [BAW-1:0]  chk_addr;
  logic [FW-1:0]   cur_frame;
  logic [FW-1:0]   taken [MAX_RUN];

  // Derived values.
  logic [8:0]      tf_words, words;
  logic            req_bad;
  logic [TAW-1:0]  page_n, page_j;
  logic            found;
  logic            scan_more;
  logic            oom;
  logic [4:0]      free_bit;
  logic [FW-1:0]   found_frame;
  logic [FW-1:0]   taken_j;
  logic [19:0]     fr20;
  logic            free_skip;
  logic            n_last, j_last, j_to_n;

  assign tf_words = {1'b0, total_frames[12:5]};
  assign words    = (tf_words > 9'(BITMAP_WORDS)) ? 9'(BITMAP_WORDS) : tf_words;

  assign req_bad = (page_count == 5'd0) || (7'(page_count) > 7'(MAX_RUN)) ||
                   ((18'(first_page) + 18'(page_count)) > 18'(TABLE_ENTRIES));

  assign page_n = first_r + TAW'(n);
  assign page_j = first_r + TAW'(j);

  // A word read in the previous cycle is checked now; a non-full one wins.
  assign found       = chk_valid && (bm_rdata != FULL_WORD);
  assign scan_more   = scan_addr < words;
  assign oom         = !chk_valid && !scan_more;
  assign free_bit    = lowest_clear(bm_rdata);
  assign found_frame = {chk_addr, free_bit};
  assign taken_j     = taken[j[RW-1:0]];

  // Frame named by a table entry, and whether it lies in the managed range.
  assign fr20      = pt_rdata[31:12] - FRAME_BASE_PG;
  assign free_skip = (pt_rdata[31:12] < FRAME_BASE_PG) ||
                     (fr20 >= 20'(total_frames)) ||
                     (fr20[19:5] >= 15'(BITMAP_WORDS));

  assign n_last = (n + NW'(1)) == count_r;
  assign j_last = (j + NW'(1)) == count_r;
  assign j_to_n = (j + NW'(1)) == n;

  assign busy = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr == TAW'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (req_bad) begin
            state_next = ST_BAD;
          end else if (req_type == REQ_FREE) begin
            state_next = ST_F_RD;
          end else begin
            state_next = ST_A_SCAN;
          end
        end
      end
      ST_BAD:      state_next = ST_IDLE;
      ST_A_SCAN: begin
        if (found) begin
          if (n_last) state_next = ST_A_EMIT;
        end else if (oom) begin
          state_next = (n == '0) ? ST_OOM_RD : ST_R_RD;
        end
      end
      ST_A_EMIT:   if (j_last) state_next = ST_IDLE;
      ST_R_RD:     state_next = ST_R_WR;
      ST_R_WR:     state_next = j_to_n ? ST_OOM_RD : ST_R_RD;
      ST_OOM_RD:   state_next = ST_OOM_EMIT;
      ST_OOM_EMIT: state_next = ST_IDLE;
      ST_F_RD:     state_next = ST_F_CHK;
      ST_F_CHK: begin
        if (!free_skip) begin
          state_next = ST_F_WR;
        end else begin
          state_next = n_last ? ST_IDLE : ST_F_RD;
        end
      end
      ST_F_WR:     state_next = n_last ? ST_IDLE : ST_F_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory port drive and result values.
  logic        res_valid_next;
  logic [9:0]  res_page_next;
  logic [11:0] res_frame_next;
  logic [31:0] res_entry_next;
  logic [2:0]  res_status_next;
  logic        res_last_next;

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = chk_addr;
    bm_wdata = bm_rdata;
    bm_raddr = scan_addr[BAW-1:0];
    pt_we    = 1'b0;
    pt_waddr = page_n;
    pt_wdata = '0;
    pt_raddr = page_n;
    res_valid_next  = 1'b0;
    res_page_next   = page_n[9:0];
    res_frame_next  = '0;
    res_entry_next  = '0;
    res_status_next = STAT_MAPPED;
    res_last_next   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr;
        bm_we    = (32'(clr) < 32'(BITMAP_WORDS));
        bm_waddr = clr[BAW-1:0];
        bm_wdata = '0;
      end
      ST_BAD: begin
        res_valid_next  = 1'b1;
        res_page_next   = first_r[9:0];
        res_status_next = STAT_BAD;
        res_last_next   = 1'b1;
      end
      ST_A_SCAN: begin
        if (found) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (32'd1 << free_bit);
          pt_we    = 1'b1;
          pt_wdata = make_entry(13'(found_frame), user_access, read_only);
        end
      end
      ST_A_EMIT: begin
        res_valid_next  = 1'b1;
        res_page_next   = page_j[9:0];
        res_frame_next  = 12'(taken_j);
        res_entry_next  = make_entry(13'(taken_j), user_access, read_only);
        res_status_next = STAT_MAPPED;
        res_last_next   = j_last;
      end
      ST_R_RD: begin
        bm_raddr = taken_j[FW-1:5];
      end
      ST_R_WR: begin
        bm_we    = 1'b1;
        bm_waddr = taken_j[FW-1:5];
        bm_wdata = bm_rdata & ~(32'd1 << taken_j[4:0]);
        pt_we    = 1'b1;
        pt_waddr = page_j;
        res_valid_next  = 1'b1;
        res_page_next   = page_j[9:0];
        res_frame_next  = 12'(taken_j);
        res_status_next = STAT_OOM;
      end
      ST_OOM_EMIT: begin
        res_valid_next  = 1'b1;
        res_entry_next  = pt_rdata;
        res_status_next = STAT_OOM;
        res_last_next   = 1'b1;
      end
      ST_F_CHK: begin
        bm_raddr = fr20[FW-1:5];
        if (free_skip) begin
          res_valid_next  = 1'b1;
          res_entry_next  = pt_rdata;
          res_status_next = STAT_SKIPPED;
          res_last_next   = n_last;
        end
      end
      ST_F_WR: begin
        bm_we    = 1'b1;
        bm_waddr = cur_frame[FW-1:5];
        bm_wdata = bm_rdata & ~(32'd1 << cur_frame[4:0]);
        pt_we    = 1'b1;
        res_valid_next  = 1'b1;
        res_frame_next  = 12'(cur_frame);
        res_status_next = STAT_FREED;
        res_last_next   = n_last;
      end
      default: ;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr          <= '0;
      result_valid <= 1'b0;
      chk_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
      if (state == ST_CLEAR) begin
        clr <= clr + TAW'(1);
      end
      if (state == ST_A_SCAN) begin
        if (found) begin
          chk_valid <= 1'b0;
        end else begin
          chk_valid <= scan_more;
        end
      end else begin
        chk_valid <= 1'b0;
      end
    end
  end

  // Request datapath registers.
  always_ff @(posedge clk) begin
    page_index   <= res_page_next;
    frame_offset <= res_frame_next;
    entry_word   <= res_entry_next;
    status       <= res_status_next;
    last         <= res_last_next;
    unique case (state)
      ST_IDLE: begin
        first_r   <= TAW'(first_page);
        count_r   <= NW'(page_count);
        n         <= '0;
        j         <= '0;
        scan_addr <= '0;
      end
      ST_A_SCAN: begin
        if (found) begin
          taken[n[RW-1:0]] <= found_frame;
          n         <= n + NW'(1);
          scan_addr <= '0;
        end else if (scan_more) begin
          chk_addr  <= scan_addr[BAW-1:0];
          scan_addr <= scan_addr + 9'd1;
        end
      end
      ST_A_EMIT, ST_R_WR: j <= j + NW'(1);
      ST_F_CHK: begin
        cur_frame <= fr20[FW-1:0];
        if (free_skip) n <= n + NW'(1);
      end
      ST_F_WR: n <= n + NW'(1);
      default: ;
    endcase
  end

endmodule

// ===== verif/bitmap_page_frame_allocator_test.sv =====
// Self-checking testbench for the bitmap page-frame allocator.
// A local predictor of the frame bitmap and page table checks every result.
// Depends on bpfa_pkg and the bitmap_page_frame_allocator RTL.
module bitmap_page_frame_allocator_test;
  import bpfa_pkg::*;

  localparam logic        REQ_ALLOC  = 1'b0;
  localparam int          NUM_WORDS  = 128;
  localparam int          NUM_PAGES  = 1024;
  localparam int          LONGEST    = 16;
  localparam logic [31:0] PHYS_BASE  = 32'h0080_0000;
  localparam logic [31:0] PAGE_MASK  = 32'hFFFF_F000;

  // One request as the stimulus side sees it. When quiesce is set, the driver
  // holds this request back until every expected result has arrived.
  typedef struct {
    logic       kind;
    logic [9:0] first;
    logic [4:0] count;
    bit         quiesce;
  } page_req_t;

  // One per-page result as the allocator should report it.
  typedef struct {
    logic [9:0]  page;
    logic [11:0] frame;
    logic [31:0] entry;
    logic [2:0]  stat;
    logic        fin;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [9:0]  first_page;
  logic [4:0]  page_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        result_valid;
  logic [9:0]  page_index;
  logic [11:0] frame_offset;
  logic [31:0] entry_word;
  logic [2:0]  status;
  logic        last;

  bitmap_page_frame_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .first_page   (first_page),
    .page_count   (page_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .page_index   (page_index),
    .frame_offset (frame_offset),
    .entry_word   (entry_word),
    .status       (status),
    .last         (last)
  );

  always #10 clk = ~clk;

  // Shadow copy of the allocator state and its configuration.
  logic [31:0] used_frames [NUM_WORDS];
  logic [31:0] page_entries [NUM_PAGES];
  logic [12:0] frame_limit;
  logic        user_bit;
  logic        ro_bit;

  page_req_t    pending_reqs [$];
  page_result_t expected_results [$];
  int           error_count = 0;
  bit           took_req;

  // Searches the shadow bitmap for the first word that is not full and takes
  // its lowest clear bit, exactly as the hardware scan does. Only the words
  // covered by the frame limit are searched, capped at the bitmap size.
  function automatic bit grab_frame(output logic [11:0] frame);
    int words;
    int b;
    words = frame_limit >> 5;
    if (words > NUM_WORDS) words = NUM_WORDS;
    frame = '0;
    for (int w = 0; w < words; w++) begin
      if (used_frames[w] != FULL_WORD) begin
        b = 0;
        while (b < 31 && used_frames[w][b]) b++;
        frame = 12'(w * 32 + b);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the results of one accepted request and updates the shadow state.
  // The whole list is built first because an out-of-memory rollback replaces
  // the mapped results of the request with rollback results.
  function automatic void predict_request(logic kind, logic [9:0] first,
                                          logic [4:0] count);
    page_result_t res [$];
    page_result_t r;
    logic [11:0]  taken [LONGEST];
    logic [11:0]  fr;
    logic [31:0]  phys;
    logic [31:0]  rel;
    int           pg;
    bit           out_of_mem;
    out_of_mem = 1'b0;
    if (count == 0 || count > LONGEST || int'(first) + int'(count) > NUM_PAGES) begin
      r = '{first, 12'd0, 32'd0, STAT_BAD, 1'b1};
      expected_results.push_back(r);
      return;
    end
    if (kind == REQ_ALLOC) begin
      for (int n = 0; n < count && !out_of_mem; n++) begin
        pg = first + n;
        if (!grab_frame(fr)) begin
          // Undo every page this request has mapped so far.
          res.delete();
          for (int j = 0; j < n; j++) begin
            used_frames[taken[j] >> 5][taken[j][4:0]] = 1'b0;
            page_entries[first + j] = '0;
            r = '{10'(first + j), taken[j], 32'd0, STAT_OOM, 1'b0};
            res.push_back(r);
          end
          r = '{10'(pg), 12'd0, page_entries[pg], STAT_OOM, 1'b0};
          res.push_back(r);
          out_of_mem = 1'b1;
        end else begin
          used_frames[fr >> 5][fr[4:0]] = 1'b1;
          taken[n] = fr;
          page_entries[pg] = (((32'(fr) << 12) + PHYS_BASE) & PAGE_MASK)
                             | {29'd0, user_bit, ~ro_bit, 1'b1};
          r = '{10'(pg), fr, page_entries[pg], STAT_MAPPED, 1'b0};
          res.push_back(r);
        end
      end
    end else begin
      for (int n = 0; n < count; n++) begin
        pg = first + n;
        phys = page_entries[pg] & PAGE_MASK;
        rel = (phys - PHYS_BASE) >> 12;
        if (phys < PHYS_BASE || rel >= 32'(frame_limit) || (rel >> 5) >= NUM_WORDS) begin
          // Entries outside the managed frames are reported and left alone.
          r = '{10'(pg), 12'd0, page_entries[pg], STAT_SKIPPED, 1'b0};
        end else begin
          used_frames[rel >> 5][rel[4:0]] = 1'b0;
          page_entries[pg] = '0;
          r = '{10'(pg), rel[11:0], 32'd0, STAT_FREED, 1'b0};
        end
        res.push_back(r);
      end
    end
    res[res.size() - 1].fin = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Monitor: records request transfers for the predictor and compares each
  // result transfer against the oldest expectation.
  always @(posedge clk) begin
    page_result_t exp_r;
    if (rst) begin
      took_req <= 1'b0;
    end else begin
      took_req <= start && !busy;
      if (start && !busy) predict_request(req_type, first_page, page_count);
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, page_index 0x%0h status %0d",
                   $time, page_index, status);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("page_index", 32'(exp_r.page), 32'(page_index));
          check_field("frame_offset", 32'(exp_r.frame), 32'(frame_offset));
          check_field("entry_word", exp_r.entry, entry_word);
          check_field("status", 32'(exp_r.stat), 32'(status));
          check_field("last", 32'(exp_r.fin), 32'(last));
        end
      end
    end
  end

  // Driver: presents queued requests at the falling edge with random gaps,
  // mostly short and occasionally long, and sometimes none at all.
  int gap_left = 0;
  always @(negedge clk) begin
    page_req_t req;
    if (!rst && (!start || took_req)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0 && pending_reqs[0].quiesce &&
                   (expected_results.size() != 0 || busy || took_req)) begin
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        start      <= 1'b1;
        req_type   <= req.kind;
        first_page <= req.first;
        page_count <= req.count;
        if ($urandom_range(0, 9) < 4) gap_left = 0;
        else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(20, 80);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_req(logic kind, int first, int count, bit quiesce = 1'b0);
    page_req_t req;
    req = '{kind, 10'(first), 5'(count), quiesce};
    pending_reqs.push_back(req);
  endtask

  // Waits until every request has gone out and every result has come back.
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || busy || start)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Performs one configuration register transfer and mirrors it.
  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TOTAL_FRAMES: frame_limit = value;
      CFG_USER_ACCESS:  user_bit = value[0];
      CFG_READ_ONLY:    ro_bit = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random requests: mostly in-range runs, many of them in a low window of
  // pages so that frees find mapped entries, with some malformed runs.
  task automatic add_random(int num);
    int first;
    int count;
    for (int i = 0; i < num; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 31));
      end else begin
        count = $urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 5);
        first = $urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(0, 1023);
        if (first + count > NUM_PAGES) first = NUM_PAGES - count;
        add_req(1'($urandom_range(0, 1)), first, count, $urandom_range(0, 29) == 0);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    req_type   = 1'b0;
    first_page = '0;
    page_count = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    foreach (used_frames[i]) used_frames[i] = '0;
    foreach (page_entries[i]) page_entries[i] = '0;
    frame_limit = 13'd4096;
    user_bit    = 1'b0;
    ro_bit      = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Default configuration: edges of the page range and malformed runs.
    add_req(REQ_ALLOC, 0, 1);
    add_req(REQ_ALLOC, 1023, 1);
    add_req(REQ_FREE, 1023, 1);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_FREE, 5, 17);
    add_req(REQ_ALLOC, 1023, 31);
    add_req(REQ_FREE, 1020, 8);
    add_req(REQ_ALLOC, 1008, 16);
    add_req(REQ_FREE, 500, 3);
    add_req(REQ_ALLOC, 0, 2, 1'b1);
    add_req(REQ_FREE, 0, 2);
    add_req(REQ_FREE, 1008, 16);
    wait_quiet();

    // One bitmap word only: user pages, read-only, and running out of frames.
    write_reg(CFG_USER_ACCESS, 13'd1);
    write_reg(CFG_READ_ONLY, 13'd1);
    write_reg(CFG_TOTAL_FRAMES, 13'd40);
    add_req(REQ_ALLOC, 100, 16);
    add_req(REQ_ALLOC, 200, 16);
    add_req(REQ_ALLOC, 300, 16);
    add_req(REQ_FREE, 200, 4);
    add_req(REQ_ALLOC, 400, 8);
    wait_quiet();

    // No managed frames: every allocation fails at once, every free skips.
    write_reg(CFG_TOTAL_FRAMES, 13'd0);
    add_req(REQ_ALLOC, 600, 3);
    add_req(REQ_FREE, 100, 4);
    wait_quiet();

    // Oversized frame count is capped at the bitmap size.
    write_reg(CFG_TOTAL_FRAMES, 13'd8191);
    write_reg(CFG_READ_ONLY, 13'd0);
    add_req(REQ_FREE, 100, 16);
    add_random(50);
    wait_quiet();

    // Random phases with changing settings, one of them short of frames.
    write_reg(CFG_TOTAL_FRAMES, 13'($urandom_range(64, 200)));
    write_reg(CFG_USER_ACCESS, 13'($urandom_range(0, 1)));
    add_random(60);
    wait_quiet();

    write_reg(CFG_TOTAL_FRAMES, 13'($urandom_range(0, 8191)));
    write_reg(CFG_READ_ONLY, 13'($urandom_range(0, 1)));
    add_random(60);
    wait_quiet();

    write_reg(CFG_TOTAL_FRAMES, 13'd4096);
    write_reg(CFG_USER_ACCESS, 13'd0);
    add_random(60);
    wait_quiet();

    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang; far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bpfa_pkg.sv
hw/rtl/bpfa_ram.sv
hw/rtl/bitmap_page_frame_allocator.sv
verif/bitmap_page_frame_allocator_test.sv
